// ===== hw/rtl/mbt_pkg.sv =====
// Package for the monobit block test: register indexes, reset values,
// queue entry type and sizing constants. No dependencies.
package mbt_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int LEN_W   = 13;
    localparam int SUM_W   = 16;
    localparam int TOTAL_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND  = 2'd2;

    localparam logic [LEN_W-1:0] BLOCK_BYTES_RST = 13'd2500;
    localparam logic [SUM_W-1:0] LOW_BOUND_RST   = 16'd9654;
    localparam logic [SUM_W-1:0] HIGH_BOUND_RST  = 16'd10346;

    typedef struct packed {
        logic [3:0] ones;
        logic       last;
    } t_mbt_entry;

endpackage

// ===== hw/rtl/mbt_in_if.sv =====
// Input channel: one random byte per beat with its end-of-sequence flag.
// No dependencies.
interface mbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_sequence;

    modport source (output valid, output data_byte, output end_of_sequence, input ready);
    modport sink   (input valid, input data_byte, input end_of_sequence, output ready);
endinterface

// ===== hw/rtl/mbt_out_if.sv =====
// Result channel: block and failure totals at the end of each sequence.
// No dependencies.
interface mbt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] block_total;
    logic [15:0] failed_total;
    logic        all_passed;

    modport source (output valid, output block_total, output failed_total,
                    output all_passed, input ready);
    modport sink   (input valid, input block_total, input failed_total,
                    input all_passed, output ready);
endinterface

// ===== hw/rtl/mbt_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
// No dependencies.
interface mbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/monobit_block_test_top.sv =====
// Top level of the monobit block test: front end, queue and back end.
// Depends on mbt_pkg, the channel interfaces, mbt_front, mbt_queue, mbt_back.
//
// Monobit health test for a random byte stream. One byte is accepted per
// cycle while the queue has room: the front end counts its one bits in the
// accept cycle and a two-entry queue feeds the back end, whose add, compare
// and counter update takes one queue entry per cycle, but an entry marked end
// of sequence waits while the previous result still waits for its sink. When
// it is popped, its totals go to the result register; other bytes keep flowing
// while a result waits, until the queue fills. Configuration writes are always
// taken (ready stays high); block_bytes of zero acts as one, a write to an
// unused index is dropped, and the totals saturate.
module monobit_block_test_top import mbt_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbt_in_if.sink     i_in,
    mbt_cfg_if.sink    i_cfg,
    mbt_out_if.source  o_out
);

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;
    t_mbt_entry push_entry;
    t_mbt_entry pop_entry;

    mbt_front u_front (
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    mbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_entry (pop_entry)
    );

    mbt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_empty (queue_empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/mbt_front.sv =====
// Front end: accepts input beats, counts the one bits of each byte and
// pushes a queue entry. Depends on mbt_pkg and mbt_in_if.
module mbt_front import mbt_pkg::*; (
    mbt_in_if.sink      i_in,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_mbt_entry  o_entry
);

    logic [3:0] ones;

    always_comb begin
        ones = 4'd0;
        for (int b = 0; b < 8; b++) begin
            ones = ones + {3'd0, i_in.data_byte[b]};
        end
    end

    assign i_in.ready    = !i_queue_full;
    assign o_push        = i_in.valid && !i_queue_full;
    assign o_entry.ones  = ones;
    assign o_entry.last  = i_in.end_of_sequence;

endmodule

// ===== hw/rtl/mbt_queue.sv =====
// Short queue between front and back end, holding classified bytes.
// Depends on mbt_pkg.
module mbt_queue import mbt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_mbt_entry  i_entry,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_mbt_entry  o_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_mbt_entry       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/mbt_back.sv =====
// Back end: configuration registers, ones accumulation, block checks,
// saturating counters and the result register. Depends on mbt_pkg,
// mbt_cfg_if and mbt_out_if.
module mbt_back import mbt_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbt_cfg_if.sink     i_cfg,
    input  logic        i_empty,
    input  t_mbt_entry  i_entry,
    output logic        o_pop,
    mbt_out_if.source   o_out
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [LEN_W-1:0]       r_block_bytes;
    logic [SUM_W-1:0]       r_low_bound;
    logic [SUM_W-1:0]       r_high_bound;

    logic [SUM_W-1:0]       r_sum,    n_sum;
    logic [LEN_W-1:0]       r_pos,    n_pos;
    logic [COUNT_WIDTH-1:0] r_seen,   n_seen;
    logic [COUNT_WIDTH-1:0] r_failed, n_failed;

    logic                   r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0]     r_block_total;
    logic [TOTAL_W-1:0]     r_failed_total;
    logic                   r_all_passed;

    logic [LEN_W-1:0]       len;
    logic [SUM_W-1:0]       sum_add;
    logic [LEN_W-1:0]       pos_add;
    logic                   close;
    logic                   pass;
    logic [31:0]            seen_ext;
    logic [31:0]            failed_ext;

    assign i_cfg.ready = 1'b1;

    assign o_pop = !i_empty && (!i_entry.last || !r_out_valid || o_out.ready);

    always_comb begin
        len      = (r_block_bytes == '0) ? LEN_W'(1) : r_block_bytes;
        sum_add  = r_sum + SUM_W'(i_entry.ones);
        pos_add  = r_pos + 1'b1;
        close    = (pos_add >= len);
        pass     = (r_low_bound < sum_add) && (sum_add < r_high_bound);
        n_sum    = close ? '0 : sum_add;
        n_pos    = close ? '0 : pos_add;
        n_seen   = r_seen;
        n_failed = r_failed;
        if (close) begin
            n_seen = (r_seen == COUNT_MAX) ? r_seen : r_seen + 1'b1;
            if (!pass) begin
                n_failed = (r_failed == COUNT_MAX) ? r_failed : r_failed + 1'b1;
            end
        end
        seen_ext   = 32'(n_seen);
        failed_ext = 32'(n_failed);
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (o_pop && i_entry.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
            r_low_bound   <= LOW_BOUND_RST;
            r_high_bound  <= HIGH_BOUND_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_BLOCK_BYTES: r_block_bytes <= i_cfg.data[LEN_W-1:0];
                REG_LOW_BOUND:   r_low_bound   <= i_cfg.data;
                REG_HIGH_BOUND:  r_high_bound  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_pos       <= '0;
            r_seen      <= '0;
            r_failed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_entry.last) begin
                    r_sum    <= '0;
                    r_pos    <= '0;
                    r_seen   <= '0;
                    r_failed <= '0;
                end else begin
                    r_sum    <= n_sum;
                    r_pos    <= n_pos;
                    r_seen   <= n_seen;
                    r_failed <= n_failed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_block_total  <= (seen_ext > 32'hFFFF) ? 16'hFFFF : seen_ext[15:0];
            r_failed_total <= (failed_ext > 32'hFFFF) ? 16'hFFFF : failed_ext[15:0];
            r_all_passed   <= (n_failed == '0);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.block_total  = r_block_total;
    assign o_out.failed_total = r_failed_total;
    assign o_out.all_passed   = r_all_passed;

endmodule

// ===== hw/rtl/mbt_checker.sv =====
// Port-level checks for the monobit block test, bound to the top level.
// Depends on monobit_block_test_top.
module mbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_block_total,
    input logic [15:0] i_failed_total,
    input logic        i_all_passed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_block_total)
            && $stable(i_failed_total) && $stable(i_all_passed))
        else $error("result beat changed while stalled");

    a_pass_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_all_passed == (i_failed_total == 16'd0)))
        else $error("all_passed disagrees with failed_total");

    a_fail_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_failed_total <= i_block_total))
        else $error("more failed blocks than blocks");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind monobit_block_test_top mbt_checker u_mbt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_ready    (i_cfg.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_block_total  (o_out.block_total),
    .i_failed_total (o_out.failed_total),
    .i_all_passed   (o_out.all_passed)
);

// ===== test/monobit_block_test_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for the monobit block test: random byte sequences, register writes and
// handshake idling, with a local model of the totals checked against every result.
// Depends on mbt_pkg, the three channel interfaces and monobit_block_test_top.
module monobit_block_test_top_test;
    import mbt_pkg::*;

    localparam int CNT_W = COUNT_WIDTH_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_SPARSE,
        FILL_DENSE
    } t_fill;

    typedef struct {
        logic [TOTAL_W-1:0] block_total;
        logic [TOTAL_W-1:0] failed_total;
        logic               all_passed;
    } t_totals;

    logic i_clk;
    logic i_rst_n;

    mbt_in_if  byte_if();
    mbt_cfg_if cfg_if();
    mbt_out_if totals_if();

    monobit_block_test_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_if),
        .i_cfg  (cfg_if),
        .o_out  (totals_if)
    );

    logic [LEN_W-1:0] blk_len;
    logic [SUM_W-1:0] low_bound;
    logic [SUM_W-1:0] high_bound;
    logic [SUM_W-1:0] ones_acc;
    logic [LEN_W-1:0] pos_acc;
    logic [CNT_W-1:0] blocks_cnt;
    logic [CNT_W-1:0] failed_cnt;

    t_totals totals_q[$];
    t_totals want_totals;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      n_bytes = 0;
    int      n_checked = 0;
    int      n_errors = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d results still pending", totals_q.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic void clear_sums();
        ones_acc   = '0;
        pos_acc    = '0;
        blocks_cnt = '0;
        failed_cnt = '0;
    endfunction

    function automatic void reg_write_model(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_BLOCK_BYTES: blk_len = val[LEN_W-1:0];
            REG_LOW_BOUND:   low_bound = val;
            REG_HIGH_BOUND:  high_bound = val;
            default: ;
        endcase
    endfunction

    function automatic void monobit_step(input logic [7:0] b, input logic eos);
        logic [LEN_W-1:0] len;
        logic             in_bounds;
        t_totals          t;
        len      = (blk_len == '0) ? LEN_W'(1) : blk_len;
        ones_acc = ones_acc + SUM_W'($countones(b));
        pos_acc  = pos_acc + 1'b1;
        if (pos_acc >= len) begin
            in_bounds = (low_bound < ones_acc) && (ones_acc < high_bound);
            if (blocks_cnt != CNT_MAX) blocks_cnt = blocks_cnt + 1'b1;
            if (!in_bounds && failed_cnt != CNT_MAX) failed_cnt = failed_cnt + 1'b1;
            ones_acc = '0;
            pos_acc  = '0;
        end
        if (eos) begin
            t.block_total  = (blocks_cnt > 65535) ? 16'hFFFF : TOTAL_W'(blocks_cnt);
            t.failed_total = (failed_cnt > 65535) ? 16'hFFFF : TOTAL_W'(failed_cnt);
            t.all_passed   = (failed_cnt == '0);
            totals_q.push_back(t);
            clear_sums();
        end
    endfunction

    function automatic logic [7:0] pick_byte(input t_fill fill);
        case (fill)
            FILL_EXTREME: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            FILL_SPARSE:  return 8'($urandom & $urandom & $urandom);
            FILL_DENSE:   return 8'($urandom | $urandom | $urandom);
            default:      return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && totals_if.valid && totals_if.ready) begin
            if (totals_q.size() == 0) begin
                report_mismatch("result with nothing pending, block_total",
                                totals_if.block_total, 0);
            end else begin
                want_totals = totals_q.pop_front();
                n_checked++;
                if (totals_if.block_total !== want_totals.block_total)
                    report_mismatch("block_total", totals_if.block_total,
                                    want_totals.block_total);
                if (totals_if.failed_total !== want_totals.failed_total)
                    report_mismatch("failed_total", totals_if.failed_total,
                                    want_totals.failed_total);
                if (totals_if.all_passed !== want_totals.all_passed)
                    report_mismatch("all_passed", totals_if.all_passed,
                                    want_totals.all_passed);
            end
        end
    end

    initial begin
        totals_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            totals_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold valid until the beat is taken
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_if.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid           = 1'b1;
        byte_if.data_byte       = b;
        byte_if.end_of_sequence = eos;
        do @(posedge i_clk); while (!byte_if.ready);
        monobit_step(b, eos);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_run(input int count, input t_fill fill, input bit close_seq);
        for (int k = 1; k <= count; k++)
            send_byte(pick_byte(fill), close_seq && (k == count));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        reg_write_model(idx, val);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input int len, input int lo, input int hi);
        write_reg(REG_BLOCK_BYTES, CFG_DATA_W'(len));
        write_reg(REG_LOW_BOUND, CFG_DATA_W'(lo));
        write_reg(REG_HIGH_BOUND, CFG_DATA_W'(hi));
        cfg_if.valid = 1'b0;
    endtask

    // drop valid, wait for all totals, then let the pipeline drain
    task automatic settle();
        byte_if.valid = 1'b0;
        while (totals_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic randomize_regs();
        int len;
        int mean;
        int lo;
        int hi;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) len = 0;
        else if (pick == 1) len = $urandom_range(9, 40);
        else len = $urandom_range(1, 8);
        mean = 4 * ((len == 0) ? 1 : len);
        lo   = mean - $urandom_range(0, mean / 2 + 2);
        if (lo < 0) lo = 0;
        hi   = mean + $urandom_range(0, mean / 2 + 2);
        pick = $urandom_range(9);
        if (pick == 0) begin
            lo = hi;
            hi = $urandom_range(0, lo);
        end else if (pick == 1) begin
            lo = 0;
            hi = 65535;
        end
        write_reg(REG_BLOCK_BYTES, {3'($urandom_range(7)), 13'(len)});
        if ($urandom_range(4) == 0) write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_LOW_BOUND, 16'(lo));
        write_reg(REG_HIGH_BOUND, 16'(hi));
        cfg_if.valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_byte(8'hA5, 1'b1);
        send_run(40, FILL_RANDOM, 1'b1);
        settle();
    endtask

    task automatic test_bounds_and_zero_length();
        program_regs(0, 0, 9);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
        program_regs(1, 3, 5);
        send_byte(8'h07, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h1F, 1'b1);
        settle();
        program_regs(1, 0, 65535);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
        program_regs(1, 65535, 0);
        send_byte(8'h55, 1'b1);
        settle();
        program_regs(1, 4, 4);
        send_byte(8'h0F, 1'b1);
        settle();
    endtask

    task automatic test_partial_block();
        program_regs(4, 0, 65535);
        send_run(3, FILL_RANDOM, 1'b1);
        send_run(9, FILL_RANDOM, 1'b1);
        settle();
    endtask

    task automatic test_length_lowered_mid_block();
        program_regs(6, 0, 65535);
        send_run(4, FILL_RANDOM, 1'b0);
        settle();
        write_reg(REG_BLOCK_BYTES, 16'd2);
        cfg_if.valid = 1'b0;
        send_byte(8'h3C, 1'b1);
        settle();
    endtask

    task automatic test_reg_decode();
        program_regs(3, 0, 65535);
        write_reg(REG_UNUSED, 16'h0000);
        write_reg(REG_BLOCK_BYTES, 16'hE002);
        cfg_if.valid = 1'b0;
        send_run(4, FILL_RANDOM, 1'b1);
        settle();
    endtask

    task automatic test_longest_block();
        program_regs(8191, 30000, 35000);
        send_run(40, FILL_RANDOM, 1'b1);
        settle();
    endtask

    task automatic test_random_traffic(input int n_target);
        int    sent;
        int    seq_len;
        int    split;
        t_fill fill;
        sent = 0;
        while (sent < n_target) begin
            if (sent == 0 || $urandom_range(2) == 0) begin
                settle();
                randomize_regs();
            end
            seq_len = ($urandom_range(7) == 0) ? $urandom_range(25, 80)
                                               : $urandom_range(1, 24);
            split = 0;
            if (seq_len > 1 && $urandom_range(5) == 0) split = $urandom_range(2, seq_len);
            fill = t_fill'($urandom_range(FILL_DENSE));
            for (int i = 1; i <= seq_len; i++) begin
                if (i == split) begin
                    settle();
                    randomize_regs();
                end
                if ($urandom_range(15) == 0) fill = t_fill'($urandom_range(FILL_DENSE));
                send_byte(pick_byte(fill), i == seq_len);
                sent++;
            end
        end
        settle();
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        byte_if.valid           = 1'b0;
        byte_if.data_byte       = '0;
        byte_if.end_of_sequence = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = '0;
        cfg_if.data             = '0;
        blk_len                 = BLOCK_BYTES_RST;
        low_bound               = LOW_BOUND_RST;
        high_bound              = HIGH_BOUND_RST;
        clear_sums();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        settle();

        send_idle_pct  = 32;
        recv_stall_pct = 81;
        test_reset_defaults();
        test_bounds_and_zero_length();
        test_partial_block();
        test_length_lowered_mid_block();
        test_reg_decode();
        test_longest_block();

        test_random_traffic(310);
        send_idle_pct  = 81;
        recv_stall_pct = 32;
        test_random_traffic(310);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(310);

        $display("Checked %0d sequence totals over %0d bytes: reset values, bound edges,",
                 n_checked, n_bytes);
        $display("zero and longest block lengths, partial blocks and random register settings.");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_in_if.sv
hw/rtl/mbt_out_if.sv
hw/rtl/mbt_cfg_if.sv
hw/rtl/mbt_front.sv
hw/rtl/mbt_queue.sv
hw/rtl/mbt_back.sv
hw/rtl/monobit_block_test_top.sv
hw/rtl/mbt_checker.sv
test/monobit_block_test_top_test.sv
